// File: sv/rcpe_pkg.sv
// Package for the Rice-coded position encoder: constants, FSM state and packer control types.
package rcpe_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int WORD_WIDTH_DEF     = 64;

    // Remainder width limits; the remainder shift register is REM_MAX bits.
    localparam int REM_MIN = 5;
    localparam int REM_MAX = 15;
    localparam int REM_CFG_W = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_REMAINDER_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH    = 1'b1;

    localparam logic [REM_CFG_W-1:0] REM_BITS_RESET = 4'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERROR,
        ST_UNARY,
        ST_STOP,
        ST_REMAIN,
        ST_FLUSH
    } rcpe_state_t;

    // Sequencer to packer, one operation per cycle at most
    typedef struct packed {
        logic push;        // append code_bit
        logic code_bit;
        logic emit_err;    // error transaction
        logic emit_flush;  // partial word, stream end
    } rcpe_pack_ctrl_t;

endpackage

// File: sv/rcpe_packer.sv
// Bit-serial word packer with output register for the Rice-coded position encoder.
module rcpe_packer #(
    parameter int WORD_WIDTH = rcpe_pkg::WORD_WIDTH_DEF,
    parameter int VB_W       = $clog2(WORD_WIDTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rcpe_pkg::rcpe_pack_ctrl_t ctrl,
    output logic                     ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [WORD_WIDTH-1:0]    out_word,
    output logic [VB_W-1:0]          out_vbits,
    output logic                     out_end,
    output logic                     out_err
);
    import rcpe_pkg::*;

    localparam int FILL_W = $clog2(WORD_WIDTH);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WORD_WIDTH - 1);

    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic                  valid_reg, valid_next;
    logic [WORD_WIDTH-1:0] word_reg, word_next;
    logic [VB_W-1:0]       vbits_reg, vbits_next;
    logic                  end_reg, end_next;
    logic                  err_reg, err_next;

    logic [WORD_WIDTH-1:0] acc_set;
    logic [FILL_W-1:0]     bit_idx;
    logic                  load;

    assign ready = !valid_reg || out_ready;

    always_comb begin
        bit_idx = FILL_LAST - fill_reg;
        acc_set = acc_reg;
        acc_set[bit_idx] = acc_reg[bit_idx] | ctrl.code_bit;
    end

    always_comb begin
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        word_next  = word_reg;
        vbits_next = vbits_reg;
        end_next   = end_reg;
        err_next   = err_reg;
        load       = 1'b0;
        priority if (ctrl.emit_err) begin
            load       = 1'b1;
            word_next  = '0;
            vbits_next = '0;
            end_next   = 1'b0;
            err_next   = 1'b1;
        end else if (ctrl.emit_flush) begin
            load       = 1'b1;
            word_next  = acc_reg;
            vbits_next = VB_W'(fill_reg);
            end_next   = 1'b1;
            err_next   = 1'b0;
            acc_next   = '0;
            fill_next  = '0;
        end else if (ctrl.push) begin
            if (fill_reg == FILL_LAST) begin
                load       = 1'b1;
                word_next  = acc_set;
                vbits_next = VB_W'(WORD_WIDTH);
                end_next   = 1'b0;
                err_next   = 1'b0;
                acc_next   = '0;
                fill_next  = '0;
            end else begin
                acc_next  = acc_set;
                fill_next = fill_reg + 1'b1;
            end
        end
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        vbits_reg <= vbits_next;
        end_reg   <= end_next;
        err_reg   <= err_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_vbits = vbits_reg;
    assign out_end   = end_reg;
    assign out_err   = err_reg;

endmodule

// File: sv/rice_coded_position_encoder_core.sv
// Rice-coded position encoder top level: sequencer, configuration and stream ports.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | tdata: position; tlast: last
//  m_      | out | m_tvalid / m_tready  | tdata: word, valid_bits; tlast: stream_end;
//          |     |                      | tuser: range or order error
//  cfg_    | in  | cfg_we               | cfg_index, cfg_data
//
// Each item is accepted in ST_IDLE, then sent as q + 1 + k code bits (q = gap >> k),
// or as an error transaction, and an item with last is followed by a flush.
// The code bits pass one per cycle through the packer's accumulator unless a held output register stalls them.
// Reset restores remainder_bits 7, code_length 2^POSITION_WIDTH and clears the stream state.
// A held output register stalls the bit sequencer; s_tready is high only between items.
module rice_coded_position_encoder_core #(
    parameter int POSITION_WIDTH = rcpe_pkg::POSITION_WIDTH_DEF,
    parameter int WORD_WIDTH     = rcpe_pkg::WORD_WIDTH_DEF,
    parameter int VB_W           = $clog2(WORD_WIDTH + 1),
    parameter int S_TDATA_W      = ((POSITION_WIDTH + 7) / 8) * 8,
    parameter int M_TDATA_W      = ((WORD_WIDTH + VB_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [S_TDATA_W-1:0]           s_tdata,   // [POSITION_WIDTH-1:0] position
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_TDATA_W-1:0]           m_tdata,   // word, then valid_bits
    output logic                           m_tlast,
    output logic                           m_tuser,   // error: position out of range or out of order
    input  logic                           cfg_we,
    input  logic [rcpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [POSITION_WIDTH:0]        cfg_data
);
    import rcpe_pkg::*;

    localparam int SHW = POSITION_WIDTH + REM_MAX;

    rcpe_state_t state_reg, state_next;

    logic [REM_CFG_W-1:0]      rem_bits_reg;
    logic [POSITION_WIDTH:0]   code_len_reg;
    logic [POSITION_WIDTH-1:0] prev_reg;
    logic                      first_reg;
    logic                      last_reg;
    logic [POSITION_WIDTH-1:0] q_cnt_reg;
    logic [REM_CFG_W-1:0]      r_cnt_reg;
    logic [REM_MAX-1:0]        rem_sr_reg;

    logic                      accept, adv, bad;
    logic [REM_CFG_W-1:0]      k;
    logic [POSITION_WIDTH-1:0] pos, gap, q;
    logic [SHW-1:0]            rem_wide;
    rcpe_pack_ctrl_t           pk;

    logic [WORD_WIDTH-1:0]     out_word;
    logic [VB_W-1:0]           out_vbits;

    assign pos      = s_tdata[POSITION_WIDTH-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        k   = (rem_bits_reg < REM_CFG_W'(REM_MIN)) ? REM_CFG_W'(REM_MIN) : rem_bits_reg;
        bad = ({1'b0, pos} >= code_len_reg) || (!first_reg && pos <= prev_reg);
        gap = first_reg ? pos : pos - prev_reg - 1'b1;
        q   = gap >> k;
        // remainder left-justified in the shift register, bits above k drop out
        rem_wide = {{REM_MAX{1'b0}}, gap} << (REM_CFG_W'(REM_MAX) - k);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (bad) state_next = ST_ERROR;
                    else if (q != '0) state_next = ST_UNARY;
                    else state_next = ST_STOP;
                end
            end
            ST_ERROR: begin
                if (adv) state_next = last_reg ? ST_FLUSH : ST_IDLE;
            end
            ST_UNARY: begin
                if (adv && q_cnt_reg == POSITION_WIDTH'(1)) state_next = ST_STOP;
            end
            ST_STOP: begin
                if (adv) state_next = ST_REMAIN;
            end
            ST_REMAIN: begin
                if (adv && r_cnt_reg == '0) state_next = last_reg ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH: begin
                if (adv) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // packer control
    always_comb begin
        pk = '0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_ERROR:  pk.emit_err   = adv;
            ST_UNARY: begin
                pk.push     = adv;
                pk.code_bit = 1'b1;
            end
            ST_STOP:   pk.push       = adv;
            ST_REMAIN: begin
                pk.push     = adv;
                pk.code_bit = rem_sr_reg[REM_MAX-1];
            end
            ST_FLUSH:  pk.emit_flush = adv;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rem_bits_reg <= REM_BITS_RESET;
            code_len_reg <= {1'b1, {POSITION_WIDTH{1'b0}}};
            prev_reg     <= '0;
            first_reg    <= 1'b1;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_REMAINDER_BITS: rem_bits_reg <= cfg_data[REM_CFG_W-1:0];
                    REG_CODE_LENGTH:    code_len_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && !bad) begin
                prev_reg  <= pos;
                first_reg <= 1'b0;
            end else if (state_reg == ST_FLUSH && adv) begin
                prev_reg  <= '0;
                first_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg   <= s_tlast;
            q_cnt_reg  <= q;
            r_cnt_reg  <= k - 1'b1;
            rem_sr_reg <= rem_wide[REM_MAX-1:0];
        end else if (adv) begin
            if (state_reg == ST_UNARY) q_cnt_reg <= q_cnt_reg - 1'b1;
            if (state_reg == ST_REMAIN) begin
                r_cnt_reg  <= r_cnt_reg - 1'b1;
                rem_sr_reg <= {rem_sr_reg[REM_MAX-2:0], 1'b0};
            end
        end
    end

    rcpe_packer #(
        .WORD_WIDTH (WORD_WIDTH),
        .VB_W       (VB_W)
    ) u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (pk),
        .ready     (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word),
        .out_vbits (out_vbits),
        .out_end   (m_tlast),
        .out_err   (m_tuser)
    );

    assign m_tdata = M_TDATA_W'({out_vbits, out_word});

`ifndef SYNTHESIS
    a_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> out_word == '0 && out_vbits == '0 && !m_tlast)
        else $error("error transaction carries data");

    a_end_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> out_vbits < VB_W'(WORD_WIDTH))
        else $error("stream end word reports a full word");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted item produced no work");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FLUSH && adv |=> first_reg && prev_reg == '0)
        else $error("flush did not clear stream state");
`endif

endmodule
